@@ hw/rtl/erpm_pkg.sv @@
// erpm_pkg: types, codes, constants and the microcode table of the rpm meter
// depends on nothing; used by every other file of the block
`timescale 1ns / 1ps

package erpm_pkg;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_PULSE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CYLINDERS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_STROKE = 4'd1;
    localparam logic [4:0] CYLINDERS_RESET   = 5'd4;
    localparam logic       FOUR_STROKE_RESET = 1'b1;

    // arithmetic constants
    localparam int          DIV_DW        = 34;
    localparam int          DIV_BITS_STEP = 2;
    localparam int          DIV_ITER      = DIV_DW / DIV_BITS_STEP;
    localparam int          DIV_CNT_W     = $clog2(DIV_ITER + 1);
    localparam logic [33:0] PER_MINUTE_US = 34'd60000000;
    localparam logic [31:0] MEAN_COUNT    = 32'd3;
    localparam logic [15:0] SAT16         = 16'hFFFF;
    localparam logic [31:0] PPM_SAT       = 32'hFFFF_FFFF;

    // micro-operations of the datapath
    typedef enum logic [3:0] {
        OP_CHECK    = 4'd0,
        OP_SPAN     = 4'd1,
        OP_FRAC_NEW = 4'd2,
        OP_FRAC_OLD = 4'd3,
        OP_PERIOD   = 4'd4,
        OP_COMMIT   = 4'd5,
        OP_DIV_PPM  = 4'd6,
        OP_AVG_SUM  = 4'd7,
        OP_DIV_MEAN = 4'd8,
        OP_DIVISOR  = 4'd9,
        OP_DIV_RPM  = 4'd10,
        OP_EMIT     = 4'd11
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT        = 3'd0,
        C_NONE        = 3'd1,
        C_PERIOD_ZERO = 3'd2,
        C_NOT_AVG     = 3'd3,
        C_ZERO_DIV    = 3'd4,
        C_END         = 3'd5
    } t_cond;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_START = 4'd0;
    localparam logic [STEP_W-1:0] STEP_AVG   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SCALE = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd11;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic none_now;
        logic acc_zero;
        logic avg;
        logic div_zero;
        logic out_free;
    } t_status;

    // read program
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_EMIT, cond: C_END, target: STEP_START};
        unique case (step)
            4'd0:    w = '{op: OP_CHECK,    cond: C_NONE,        target: STEP_AVG};
            4'd1:    w = '{op: OP_SPAN,     cond: C_NEXT,        target: STEP_START};
            4'd2:    w = '{op: OP_FRAC_NEW, cond: C_NEXT,        target: STEP_START};
            4'd3:    w = '{op: OP_FRAC_OLD, cond: C_NEXT,        target: STEP_START};
            4'd4:    w = '{op: OP_PERIOD,   cond: C_NEXT,        target: STEP_START};
            4'd5:    w = '{op: OP_COMMIT,   cond: C_PERIOD_ZERO, target: STEP_AVG};
            4'd6:    w = '{op: OP_DIV_PPM,  cond: C_NEXT,        target: STEP_START};
            4'd7:    w = '{op: OP_AVG_SUM,  cond: C_NOT_AVG,     target: STEP_SCALE};
            4'd8:    w = '{op: OP_DIV_MEAN, cond: C_NEXT,        target: STEP_START};
            4'd9:    w = '{op: OP_DIVISOR,  cond: C_ZERO_DIV,    target: STEP_EMIT};
            4'd10:   w = '{op: OP_DIV_RPM,  cond: C_NEXT,        target: STEP_START};
            4'd11:   w = '{op: OP_EMIT,     cond: C_END,         target: STEP_START};
            default: w = '{op: OP_EMIT,     cond: C_END,         target: STEP_START};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/erpm_if.sv @@
// erpm_if: valid/ready channels of the rpm meter (input items, results, config)
// depends on erpm_pkg for the config widths
`timescale 1ns / 1ps

interface erpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] sub_tick;
    logic       averaged;
    modport source (output valid, kind, sub_tick, averaged, input ready);
    modport sink   (input valid, kind, sub_tick, averaged, output ready);
endinterface

interface erpm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rpm;
    logic        no_pulse;
    modport source (output valid, rpm, no_pulse, input ready);
    modport sink   (input valid, rpm, no_pulse, output ready);
endinterface

interface erpm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [erpm_pkg::CFG_IDX_W-1:0]  index;
    logic [erpm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/erpm_div.sv @@
// erpm_div: shared unsigned restoring divider, two quotient bits per cycle
// depends on erpm_pkg for widths and iteration count
`timescale 1ns / 1ps

module erpm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [erpm_pkg::DIV_DW-1:0] i_dividend,
    input  logic [31:0]                 i_divisor,
    output logic                        o_done,
    output logic [erpm_pkg::DIV_DW-1:0] o_quotient
);

    logic [31:0]                        r_rem, n_rem;
    logic [erpm_pkg::DIV_DW-1:0]        r_quo, n_quo;
    logic [31:0]                        r_dvs;
    logic [erpm_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                               r_run;
    logic                               r_done;

    // two shift-subtract steps
    always_comb begin
        logic [32:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < erpm_pkg::DIV_BITS_STEP; k++) begin
            trial = {n_rem, n_quo[erpm_pkg::DIV_DW-1]};
            n_quo = {n_quo[erpm_pkg::DIV_DW-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                trial    = trial - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[31:0];
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= erpm_pkg::DIV_CNT_W'(erpm_pkg::DIV_ITER);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == erpm_pkg::DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hw/rtl/erpm_seq.sv @@
// erpm_seq: step counter and microcode sequencer of the read program
// depends on erpm_pkg for the control word table and control structs
`timescale 1ns / 1ps

module erpm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_read_start,
    input  erpm_pkg::t_status i_status,
    input  logic              i_div_done,
    output logic              o_div_start,
    output erpm_pkg::t_ctrl   o_ctrl,
    output logic              o_busy
);

    logic [erpm_pkg::STEP_W-1:0] r_step;
    logic                        r_busy;
    logic                        r_issued;
    erpm_pkg::t_uword            uw;
    logic                        is_div;
    logic                        fire;
    logic                        take;

    assign uw = erpm_pkg::ucode(r_step);

    assign is_div = uw.op inside {erpm_pkg::OP_FRAC_NEW, erpm_pkg::OP_FRAC_OLD,
                                  erpm_pkg::OP_PERIOD, erpm_pkg::OP_DIV_PPM,
                                  erpm_pkg::OP_DIV_MEAN, erpm_pkg::OP_DIV_RPM};

    // a step completes after its division, after the output frees, or at once
    always_comb begin
        if (!r_busy)
            fire = 1'b0;
        else if (is_div)
            fire = i_div_done && r_issued;
        else if (uw.op == erpm_pkg::OP_EMIT)
            fire = i_status.out_free;
        else
            fire = 1'b1;
    end

    // jump condition
    always_comb begin
        unique case (uw.cond)
            erpm_pkg::C_NEXT:        take = 1'b0;
            erpm_pkg::C_NONE:        take = i_status.none_now;
            erpm_pkg::C_PERIOD_ZERO: take = i_status.acc_zero;
            erpm_pkg::C_NOT_AVG:     take = !i_status.avg;
            erpm_pkg::C_ZERO_DIV:    take = i_status.div_zero;
            erpm_pkg::C_END:         take = 1'b1;
            default:                 take = 1'b0;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= erpm_pkg::STEP_START;
            r_issued <= 1'b0;
        end else begin
            if (o_div_start)
                r_issued <= 1'b1;
            if (i_read_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= erpm_pkg::STEP_START;
            end else if (fire) begin
                r_issued <= 1'b0;
                if (uw.cond == erpm_pkg::C_END)
                    r_busy <= 1'b0;
                else if (take)
                    r_step <= uw.target;
                else
                    r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_div_start = r_busy && is_div && !r_issued;
    assign o_ctrl      = '{op: uw.op, fire: fire};
    assign o_busy      = r_busy;

endmodule

@@ hw/rtl/erpm_dp.sv @@
// erpm_dp: counters, reference values, history, operand select and result register
// depends on erpm_pkg; works under erpm_seq control with erpm_div
`timescale 1ns / 1ps

module erpm_dp #(
    parameter int TICK_US      = 1024,
    parameter int FRACTION_TOP = 255
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_kind,
    input  logic [7:0]                  i_sub_tick,
    input  logic                        i_averaged,
    input  logic [4:0]                  i_cylinders,
    input  logic                        i_four_stroke,
    input  erpm_pkg::t_ctrl             i_ctrl,
    input  logic [erpm_pkg::DIV_DW-1:0] i_div_quo,
    output logic [erpm_pkg::DIV_DW-1:0] o_div_dividend,
    output logic [31:0]                 o_div_divisor,
    output erpm_pkg::t_status           o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [15:0]                 o_rpm,
    output logic                        o_no_pulse
);

    localparam logic [15:0] US  = 16'(TICK_US);
    localparam logic [7:0]  TOP = 8'(FRACTION_TOP);

    logic [31:0] r_tick_count, r_pulse_count, r_tick_at_pulse;
    logic [7:0]  r_fraction_at_pulse;
    logic [31:0] r_prev_tick, r_prev_pulses;
    logic [7:0]  r_prev_fraction;
    logic [31:0] r_history_one, r_history_two;
    logic [31:0] r_acc, r_cnt_n, r_ppm;
    logic [33:0] r_sum;
    logic        r_avg, r_none;
    logic [4:0]  r_divisor;
    logic        r_out_valid;
    logic [15:0] r_rpm;
    logic [15:0] r_out_rpm;
    logic        r_out_no_pulse;

    logic [47:0] span_prod;
    logic [23:0] frac_new_prod, frac_old_prod;
    logic [4:0]  divisor_now;
    logic        exec;
    logic [7:0]  sub_clamped;

    assign span_prod     = 48'(r_tick_at_pulse - r_prev_tick) * 48'(US);
    assign frac_new_prod = 24'(r_fraction_at_pulse) * 24'(US);
    assign frac_old_prod = 24'(TOP - r_prev_fraction) * 24'(US);
    assign divisor_now   = i_four_stroke ? {1'b0, i_cylinders[4:1]} : i_cylinders;
    assign sub_clamped   = (i_sub_tick > TOP) ? TOP : i_sub_tick;
    assign exec          = i_ctrl.fire;

    // divider operand select
    always_comb begin
        o_div_dividend = '0;
        o_div_divisor  = 32'd1;
        case (i_ctrl.op)
            erpm_pkg::OP_FRAC_NEW: begin
                o_div_dividend = 34'(frac_new_prod);
                o_div_divisor  = 32'(TOP);
            end
            erpm_pkg::OP_FRAC_OLD: begin
                o_div_dividend = 34'(frac_old_prod);
                o_div_divisor  = 32'(TOP);
            end
            erpm_pkg::OP_PERIOD: begin
                o_div_dividend = 34'(r_acc);
                o_div_divisor  = r_cnt_n;
            end
            erpm_pkg::OP_DIV_PPM: begin
                o_div_dividend = erpm_pkg::PER_MINUTE_US;
                o_div_divisor  = r_acc;
            end
            erpm_pkg::OP_DIV_MEAN: begin
                o_div_dividend = r_sum;
                o_div_divisor  = erpm_pkg::MEAN_COUNT;
            end
            erpm_pkg::OP_DIV_RPM: begin
                o_div_dividend = 34'(r_ppm);
                o_div_divisor  = 32'(r_divisor);
            end
            default: begin
                o_div_dividend = '0;
                o_div_divisor  = 32'd1;
            end
        endcase
    end

    // input items: counters, pulse capture and the averaged flag of a read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count        <= '0;
            r_pulse_count       <= '0;
            r_tick_at_pulse     <= '0;
            r_fraction_at_pulse <= '0;
            r_avg               <= 1'b0;
        end else if (i_accept) begin
            case (erpm_pkg::t_kind'(i_kind))
                erpm_pkg::KIND_TICK: r_tick_count <= r_tick_count + 32'd1;
                erpm_pkg::KIND_PULSE: begin
                    r_tick_at_pulse     <= r_tick_count;
                    r_fraction_at_pulse <= sub_clamped;
                    r_pulse_count       <= r_pulse_count + 32'd1;
                end
                erpm_pkg::KIND_READ: r_avg <= i_averaged;
                default: ;
            endcase
        end
    end

    // read program state: references and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tick     <= '0;
            r_prev_pulses   <= '0;
            r_prev_fraction <= '0;
            r_history_one   <= '0;
            r_history_two   <= '0;
        end else if (exec) begin
            case (i_ctrl.op)
                erpm_pkg::OP_COMMIT: begin
                    r_prev_tick     <= r_tick_at_pulse;
                    r_prev_pulses   <= r_pulse_count;
                    r_prev_fraction <= r_fraction_at_pulse;
                end
                erpm_pkg::OP_AVG_SUM: begin
                    if (r_avg) begin
                        r_history_two <= r_history_one;
                        r_history_one <= r_ppm;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers of the read program
    always_ff @(posedge i_clk) begin
        if (exec) begin
            case (i_ctrl.op)
                erpm_pkg::OP_CHECK: begin
                    r_none <= (r_pulse_count == r_prev_pulses);
                    r_ppm  <= '0;
                end
                erpm_pkg::OP_SPAN: begin
                    r_acc   <= span_prod[31:0];
                    r_cnt_n <= r_pulse_count - r_prev_pulses;
                end
                erpm_pkg::OP_FRAC_NEW: r_acc <= r_acc + i_div_quo[31:0];
                erpm_pkg::OP_FRAC_OLD: r_acc <= r_acc - i_div_quo[31:0];
                erpm_pkg::OP_PERIOD:   r_acc <= i_div_quo[31:0];
                erpm_pkg::OP_COMMIT:   r_ppm <= erpm_pkg::PPM_SAT;
                erpm_pkg::OP_DIV_PPM:  r_ppm <= i_div_quo[31:0];
                erpm_pkg::OP_AVG_SUM:
                    r_sum <= 34'(r_ppm) + 34'(r_history_one) + 34'(r_history_two);
                erpm_pkg::OP_DIV_MEAN: r_ppm <= i_div_quo[31:0];
                erpm_pkg::OP_DIVISOR: begin
                    r_divisor <= divisor_now;
                    r_rpm     <= erpm_pkg::SAT16;
                end
                erpm_pkg::OP_DIV_RPM:
                    r_rpm <= (i_div_quo[33:16] != '0) ? erpm_pkg::SAT16 : i_div_quo[15:0];
                default: ;
            endcase
        end
    end

    // result register, loaded only at the emit step so a held word stays put
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_out_rpm      <= '0;
            r_out_no_pulse <= 1'b0;
        end else begin
            if (exec && i_ctrl.op == erpm_pkg::OP_EMIT) begin
                r_out_valid    <= 1'b1;
                r_out_rpm      <= r_rpm;
                r_out_no_pulse <= r_none;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status = '{
        none_now: (r_pulse_count == r_prev_pulses),
        acc_zero: (r_acc == '0),
        avg:      r_avg,
        div_zero: (divisor_now == '0),
        out_free: (!r_out_valid || i_out_ready)
    };

    assign o_out_valid = r_out_valid;
    assign o_rpm       = r_out_rpm;
    assign o_no_pulse  = r_out_no_pulse;

endmodule

@@ hw/rtl/engine_rpm_pulse_meter.sv @@
// engine_rpm_pulse_meter: top level, configuration registers and channel wiring
// depends on erpm_pkg, erpm_if, erpm_div, erpm_seq and erpm_dp
//
// Usage. Items arrive on i_in_ch: kind 0 counts a timer overflow tick, kind 1
// records a breaker pulse with its sub-tick fraction, kind 2 asks for a reading
// (averaged selects the three-sample mean). Kind 3 is ignored. Only a read gives
// a word on o_out_ch: rpm, saturated at 65535, and no_pulse. i_cfg_ch writes
// cylinders (index 0) and four_stroke (index 1); it is always ready. It must be
// written only while the block is idle; the block itself does not enforce this.
// Throughput. Ticks and pulses take one cycle each. A read runs a short
// microcode program whose cost is set by the shared radix-4 divider: each
// division step waits for its quotient, the emit step for a free output
// register, and every other step completes without waiting. A read does none
// (no new pulses, plain mode, zero divisor) up to 6 divisions before its word
// is loaded. i_in_ch.ready is low while a read is in progress.
// Stall. The result sits in an output register; a held word only holds the
// read that follows at its last step, ticks and pulses are still taken until
// that read starts.
// Reset. Synchronous active-low i_rst_n clears all counters, reference values
// and history to zero, sets cylinders to 4 and four_stroke to 1.
`timescale 1ns / 1ps

module engine_rpm_pulse_meter #(
    parameter int TICK_US      = 1024,
    parameter int FRACTION_TOP = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    erpm_in_if.sink    i_in_ch,
    erpm_out_if.source o_out_ch,
    erpm_cfg_if.sink   i_cfg_ch
);

    logic                        r_four_stroke;
    logic [4:0]                  r_cylinders;
    logic                        busy;
    logic                        in_accept;
    logic                        read_start;
    logic                        div_start;
    logic                        div_done;
    logic [erpm_pkg::DIV_DW-1:0] div_quo;
    logic [erpm_pkg::DIV_DW-1:0] div_dividend;
    logic [31:0]                 div_divisor;
    erpm_pkg::t_ctrl             ctrl;
    erpm_pkg::t_status           status;

    // configuration registers
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cylinders   <= erpm_pkg::CYLINDERS_RESET;
            r_four_stroke <= erpm_pkg::FOUR_STROKE_RESET;
        end else if (i_cfg_ch.valid) begin
            if (i_cfg_ch.index == erpm_pkg::CFG_CYLINDERS)
                r_cylinders <= i_cfg_ch.data[4:0];
            else if (i_cfg_ch.index == erpm_pkg::CFG_FOUR_STROKE)
                r_four_stroke <= i_cfg_ch.data[0];
        end
    end

    // input handshake
    assign i_in_ch.ready = !busy;
    assign in_accept     = i_in_ch.valid && !busy;
    assign read_start    = in_accept && (i_in_ch.kind == erpm_pkg::KIND_READ);

    erpm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_read_start (read_start),
        .i_status     (status),
        .i_div_done   (div_done),
        .o_div_start  (div_start),
        .o_ctrl       (ctrl),
        .o_busy       (busy)
    );

    erpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    erpm_dp #(
        .TICK_US      (TICK_US),
        .FRACTION_TOP (FRACTION_TOP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_kind         (i_in_ch.kind),
        .i_sub_tick     (i_in_ch.sub_tick),
        .i_averaged     (i_in_ch.averaged),
        .i_cylinders    (r_cylinders),
        .i_four_stroke  (r_four_stroke),
        .i_ctrl         (ctrl),
        .i_div_quo      (div_quo),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .o_status       (status),
        .o_out_valid    (o_out_ch.valid),
        .i_out_ready    (o_out_ch.ready),
        .o_rpm          (o_out_ch.rpm),
        .o_no_pulse     (o_out_ch.no_pulse)
    );

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for engine_rpm_pulse_meter with a cycle-free rpm predictor
// depends on erpm_pkg, erpm_if and the engine_rpm_pulse_meter rtl
`timescale 1ns / 1ps

module tb;

    // bench constants
    localparam logic [1:0]                     KIND_UNUSED   = 2'd3;
    localparam logic [erpm_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 4'd5;
    localparam bit [31:0]                      TICK_US_W     = 32'd1024;
    localparam bit [31:0]                      FRAC_TOP_W    = 32'd255;
    localparam bit [31:0]                      US_PER_MINUTE = 32'd60000000;
    localparam int                             READ_LATENCY  = 150;
    localparam int                             DRAIN_LIMIT   = 20000;
    localparam int                             HOLD_LEN      = 600;
    localparam int                             IDLE_PCT      = 31;

    typedef struct {
        logic [15:0] rpm;
        logic        no_pulse;
    } t_reading;

    logic clk;
    logic rst_n;

    erpm_in_if  in_ch();
    erpm_out_if out_ch();
    erpm_cfg_if cfg_ch();

    engine_rpm_pulse_meter u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch),
        .i_cfg_ch(cfg_ch)
    );

    // predictor state
    bit [4:0]  cyl_cfg;
    bit        four_stroke_cfg;
    bit [31:0] tick_count;
    bit [31:0] pulse_count;
    bit [31:0] tick_at_pulse;
    bit [7:0]  frac_at_pulse;
    bit [31:0] ref_tick;
    bit [31:0] ref_pulses;
    bit [7:0]  ref_frac;
    bit [31:0] hist_one;
    bit [31:0] hist_two;

    t_reading readings_due[$];
    int       fails;
    int       words_sent;
    bit       tx_steady;
    logic     rx_steady;
    int       hold_seq;
    int       hold_seen;
    int       hold_left;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("engine_rpm_pulse_meter verification failed");
        $finish;
    end

    // rpm a read word should report, from the predictor state
    function automatic t_reading reading_for(input logic avg);
        t_reading  r;
        bit [31:0] n, elapsed, period, ppm, div, q;
        bit [33:0] sum;
        r.no_pulse = (pulse_count == ref_pulses);
        if (r.no_pulse) begin
            ppm = 32'd0;
        end else begin
            n       = pulse_count - ref_pulses;
            elapsed = (tick_at_pulse - ref_tick) * TICK_US_W;
            elapsed = elapsed + ({24'd0, frac_at_pulse} * TICK_US_W) / FRAC_TOP_W;
            elapsed = elapsed - ((FRAC_TOP_W - {24'd0, ref_frac}) * TICK_US_W) / FRAC_TOP_W;
            period  = elapsed / n;
            ref_tick   = tick_at_pulse;
            ref_pulses = pulse_count;
            ref_frac   = frac_at_pulse;
            ppm = (period == 32'd0) ? 32'hFFFF_FFFF : US_PER_MINUTE / period;
        end
        // three-sample mean, summed without wrap
        if (avg) begin
            sum      = {2'b00, ppm} + {2'b00, hist_one} + {2'b00, hist_two};
            hist_two = hist_one;
            hist_one = ppm;
            ppm      = 32'(sum / 34'd3);
        end
        div = four_stroke_cfg ? {28'd0, cyl_cfg[4:1]} : {27'd0, cyl_cfg};
        if (div == 32'd0) begin
            r.rpm = 16'hFFFF;
        end else begin
            q     = ppm / div;
            r.rpm = (q > 32'd65535) ? 16'hFFFF : q[15:0];
        end
        return r;
    endfunction

    // fold one accepted input word into the predictor
    task automatic meter_accept(input logic [1:0] kind, input logic [7:0] sub, input logic avg);
        case (kind)
            erpm_pkg::KIND_TICK: begin
                tick_count = tick_count + 1;
            end
            erpm_pkg::KIND_PULSE: begin
                tick_at_pulse = tick_count;
                frac_at_pulse = ({24'd0, sub} > FRAC_TOP_W) ? FRAC_TOP_W[7:0] : sub;
                pulse_count   = pulse_count + 1;
            end
            erpm_pkg::KIND_READ: begin
                readings_due.push_back(reading_for(avg));
            end
            default: ;
        endcase
    endtask

    // one input word, with a random gap in front unless the sender runs steady
    task automatic send_item(input logic [1:0] kind, input logic [7:0] sub, input logic avg);
        if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.sub_tick <= sub;
        in_ch.averaged <= avg;
        do @(posedge clk); while (!in_ch.ready);
        meter_accept(kind, sub, avg);
        if (kind != KIND_UNUSED) words_sent++;
    endtask

    task automatic pause_input();
        in_ch.valid <= 1'b0;
    endtask

    // wait for all readings, then for any tick or pulse still in flight
    task automatic settle();
        pause_input();
        while (readings_due.size() != 0) @(posedge clk);
        repeat (READ_LATENCY) @(posedge clk);
    endtask

    // one register write; valid stays up for a following write
    task automatic write_reg(input logic [erpm_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [erpm_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == erpm_pkg::CFG_CYLINDERS) cyl_cfg = val[4:0];
        else if (idx == erpm_pkg::CFG_FOUR_STROKE) four_stroke_cfg = val[0];
    endtask

    // rewrite both registers while idle; upper data bits are don't-care
    task automatic configure(input logic [4:0] cyl, input logic fs);
        settle();
        write_reg(erpm_pkg::CFG_CYLINDERS, {3'($urandom_range(7)), cyl});
        write_reg(erpm_pkg::CFG_FOUR_STROKE, {7'($urandom_range(127)), fs});
        cfg_ch.valid <= 1'b0;
    endtask

    // engine-like traffic: ticks and pulses closed by a read, with some noise words
    task automatic run_engine(input int target);
        int pulses;
        int ticks;
        while (words_sent < target) begin
            if ($urandom_range(99) < 12) begin
                send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            end else begin
                pulses = $urandom_range(0, 4);
                repeat (pulses) begin
                    ticks = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
                    repeat (ticks) send_item(erpm_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
                    send_item(erpm_pkg::KIND_PULSE, 8'($urandom), 1'($urandom));
                end
                send_item(erpm_pkg::KIND_READ, 8'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    // hand-picked words: empty reads, zero period, fraction extremes, ignored fields
    task automatic test_directed_cases();
        send_item(erpm_pkg::KIND_READ, 8'h00, 1'b0);
        send_item(erpm_pkg::KIND_READ, 8'hFF, 1'b1);
        send_item(KIND_UNUSED, 8'hA5, 1'b1);
        send_item(erpm_pkg::KIND_TICK, 8'hFF, 1'b1);
        send_item(erpm_pkg::KIND_PULSE, 8'h00, 1'b1);
        send_item(erpm_pkg::KIND_READ, 8'h00, 1'b0);
        repeat (3) send_item(erpm_pkg::KIND_TICK, 8'h5A, 1'b0);
        send_item(erpm_pkg::KIND_PULSE, 8'hFF, 1'b0);
        send_item(erpm_pkg::KIND_READ, 8'h00, 1'b1);
        // pulse in the same tick right after a full fraction: zero elapsed time
        send_item(erpm_pkg::KIND_PULSE, 8'h00, 1'b0);
        send_item(erpm_pkg::KIND_READ, 8'hFF, 1'b0);
        send_item(erpm_pkg::KIND_TICK, 8'h00, 1'b0);
        send_item(erpm_pkg::KIND_PULSE, 8'h80, 1'b0);
        send_item(erpm_pkg::KIND_TICK, 8'h00, 1'b1);
        send_item(erpm_pkg::KIND_PULSE, 8'h01, 1'b0);
        send_item(erpm_pkg::KIND_READ, 8'h00, 1'b1);
        send_item(erpm_pkg::KIND_READ, 8'h00, 1'b1);
        send_item(KIND_UNUSED, 8'h00, 1'b0);
        send_item(erpm_pkg::KIND_READ, 8'h00, 1'b0);
    endtask

    // register extremes, zero divisors among them, plus a write to an unused index
    task automatic test_config_sweep();
        logic [4:0] cyl_set[8] = '{5'd0, 5'd1, 5'd1, 5'd16, 5'd16, 5'd31, 5'd2, 5'd4};
        logic       fs_set[8]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
        for (int i = 0; i < 8; i++) begin
            configure(cyl_set[i], fs_set[i]);
            if (i == 3) begin
                write_reg(CFG_SPARE, 8'($urandom));
                cfg_ch.valid <= 1'b0;
            end
            run_engine(words_sent + 70);
        end
    endtask

    // bulk random traffic: a steady stretch first, then random settings
    task automatic test_random_traffic();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        run_engine(words_sent + 150);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        while (words_sent < 1150) begin
            configure(5'($urandom_range(31)), 1'($urandom_range(1)));
            run_engine(words_sent + 100);
        end
    endtask

    // result side held off while reads keep coming, so the input stalls
    task automatic test_output_backpressure();
        configure(5'd6, 1'b1);
        hold_seq <= hold_seq + 1;
        run_engine(words_sent + 100);
    endtask

    // result side: random ready, a steady stretch, and a counted hold-off
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_LEN;
            out_ch.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            out_ch.ready  <= 1'b0;
        end else begin
            out_ch.ready  <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare each result word with the oldest reading due
    always @(posedge clk) begin
        t_reading due;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (readings_due.size() == 0) begin
                $error("result word with no reading due: rpm %0d no_pulse %0d",
                       out_ch.rpm, out_ch.no_pulse);
                fails++;
            end else begin
                due = readings_due.pop_front();
                if (out_ch.rpm !== due.rpm) begin
                    $error("rpm mismatch: expected %0d, actual %0d", due.rpm, out_ch.rpm);
                    fails++;
                end
                if (out_ch.no_pulse !== due.no_pulse) begin
                    $error("no_pulse mismatch: expected %0d, actual %0d",
                           due.no_pulse, out_ch.no_pulse);
                    fails++;
                end
            end
        end
    end

    // main sequence
    initial begin
        int waited;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= erpm_pkg::KIND_TICK;
        in_ch.sub_tick <= 8'd0;
        in_ch.averaged <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= erpm_pkg::CFG_CYLINDERS;
        cfg_ch.data    <= 8'd0;
        rx_steady      <= 1'b0;
        hold_seq       <= 0;
        tx_steady       = 1'b0;
        fails           = 0;
        words_sent      = 0;
        cyl_cfg         = erpm_pkg::CYLINDERS_RESET;
        four_stroke_cfg = erpm_pkg::FOUR_STROKE_RESET;
        tick_count      = '0;
        pulse_count     = '0;
        tick_at_pulse   = '0;
        frac_at_pulse   = '0;
        ref_tick        = '0;
        ref_pulses      = '0;
        ref_frac        = '0;
        hist_one        = '0;
        hist_two        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_config_sweep();
        test_random_traffic();
        test_output_backpressure();

        // drain, then give stray words time to show up
        pause_input();
        waited = 0;
        while (readings_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (readings_due.size() != 0) begin
            $error("%0d readings never arrived", readings_due.size());
            fails++;
        end
        repeat (READ_LATENCY) @(posedge clk);
        if (fails == 0)
            $display("engine_rpm_pulse_meter verification clean");
        else
            $display("engine_rpm_pulse_meter verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/erpm_pkg.sv
hw/rtl/erpm_if.sv
hw/rtl/erpm_div.sv
hw/rtl/erpm_seq.sv
hw/rtl/erpm_dp.sv
hw/rtl/engine_rpm_pulse_meter.sv
verif/tb.sv
